// ----- rtl/ecpr_pkg.sv -----
`timescale 1ns / 1ps
package ecpr_pkg;

	localparam int FRAMES    = 4;
	localparam int PAGE_BITS = 16;
	localparam int FRAME_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;

	localparam int IDX_W  = 2;
	localparam int PORT_W = 16;

	typedef logic [PAGE_BITS-1:0] page_t;
	typedef logic [FRAME_W-1:0]   frame_t;
	typedef logic [1:0]           pass_t;

	localparam pass_t PASS_FIRST = 2'd0;
	localparam pass_t PASS_LAST  = 2'd3;

	typedef struct packed {
		logic load;
		logic look;
		logic scan;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic hit;
		logic found;
	} sts_t;

endpackage

// ----- rtl/ecpr_ctrl.sv -----
`timescale 1ns / 1ps
module ecpr_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  ecpr_pkg::sts_t  sts,
	output ecpr_pkg::cmd_t  cmd
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_LOOK   = 4'b0010,
		ST_SCAN   = 4'b0100,
		ST_COMMIT = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_LOOK;
				end
			end
			ST_LOOK: begin
				cmd.look = 1'b1;
				state_d  = sts.hit ? ST_COMMIT : ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.found) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				if (!out_valid_q || out_ready) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ----- rtl/ecpr_datapath.sv -----
`timescale 1ns / 1ps
module ecpr_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ecpr_pkg::cmd_t                cmd,
	output ecpr_pkg::sts_t                sts,
	input  logic [15:0]                   page_number,
	input  logic                          is_write,
	output logic                          hit,
	output logic [ecpr_pkg::IDX_W-1:0]    frame_index,
	output logic [ecpr_pkg::PORT_W-1:0]   evicted_page,
	output logic                          evicted_modified
);

	localparam int SUM_W = ecpr_pkg::FRAME_W + 1;

	ecpr_pkg::page_t  page_q;
	logic             wr_q;
	ecpr_pkg::page_t  frame_page_q [ecpr_pkg::FRAMES];
	logic [ecpr_pkg::FRAMES-1:0] ref_q;
	logic [ecpr_pkg::FRAMES-1:0] mod_q;
	ecpr_pkg::frame_t hand_q;
	ecpr_pkg::pass_t  pass_q;
	logic             hit_q;
	ecpr_pkg::frame_t victim_q;

	logic                        res_hit_q;
	logic [ecpr_pkg::IDX_W-1:0]  res_idx_q;
	logic [ecpr_pkg::PORT_W-1:0] res_page_q;
	logic                        res_mod_q;

	logic             hit_any;
	ecpr_pkg::frame_t hit_idx;
	ecpr_pkg::frame_t rot_idx [ecpr_pkg::FRAMES];
	logic [ecpr_pkg::FRAMES-1:0] match_rot;
	logic             found;
	ecpr_pkg::frame_t sel_j;
	logic             found_eff;
	ecpr_pkg::frame_t scan_victim;
	logic [ecpr_pkg::FRAMES-1:0] clr_f;
	logic             want_mod;

	// tag compare, lowest frame wins
	always_comb begin
		hit_any = 1'b0;
		hit_idx = '0;
		for (int i = ecpr_pkg::FRAMES - 1; i >= 0; i--) begin
			if (frame_page_q[i] == page_q) begin
				hit_any = 1'b1;
				hit_idx = ecpr_pkg::FRAME_W'(i);
			end
		end
	end

	// frame order starting at the hand
	always_comb begin
		logic [SUM_W-1:0] sum;
		for (int j = 0; j < ecpr_pkg::FRAMES; j++) begin
			sum = {1'b0, hand_q} + SUM_W'(j);
			if (sum >= SUM_W'(ecpr_pkg::FRAMES)) begin
				sum = sum - SUM_W'(ecpr_pkg::FRAMES);
			end
			rot_idx[j] = sum[ecpr_pkg::FRAME_W-1:0];
		end
	end

	assign want_mod = pass_q[0];

	always_comb begin
		for (int j = 0; j < ecpr_pkg::FRAMES; j++) begin
			match_rot[j] = !ref_q[rot_idx[j]] && (mod_q[rot_idx[j]] == want_mod);
		end
	end

	always_comb begin
		found = 1'b0;
		sel_j = '0;
		for (int j = ecpr_pkg::FRAMES - 1; j >= 0; j--) begin
			if (match_rot[j]) begin
				found = 1'b1;
				sel_j = ecpr_pkg::FRAME_W'(j);
			end
		end
	end

	assign found_eff   = found || (pass_q == ecpr_pkg::PASS_LAST);
	assign scan_victim = found ? rot_idx[sel_j] : hand_q;

	// odd passes clear the reference bits of the frames passed over
	always_comb begin
		clr_f = '0;
		for (int j = 0; j < ecpr_pkg::FRAMES; j++) begin
			if (want_mod && (!found || (ecpr_pkg::FRAME_W'(j) < sel_j))) begin
				clr_f[rot_idx[j]] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			page_q <= ecpr_pkg::PAGE_BITS'(page_number);
			wr_q   <= is_write;
		end
		if (cmd.commit) begin
			res_hit_q <= hit_q;
			res_idx_q <= ecpr_pkg::IDX_W'(victim_q);
			if (hit_q) begin
				res_page_q <= '0;
				res_mod_q  <= 1'b0;
			end else begin
				res_page_q <= ecpr_pkg::PORT_W'(frame_page_q[victim_q]);
				res_mod_q  <= mod_q[victim_q];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ecpr_pkg::FRAMES; i++) begin
				frame_page_q[i] <= '0;
			end
			ref_q    <= '0;
			mod_q    <= '0;
			hand_q   <= '0;
			pass_q   <= ecpr_pkg::PASS_FIRST;
			hit_q    <= 1'b0;
			victim_q <= '0;
		end else begin
			if (cmd.look) begin
				hit_q    <= hit_any;
				victim_q <= hit_idx;
				pass_q   <= ecpr_pkg::PASS_FIRST;
			end
			if (cmd.scan) begin
				ref_q <= ref_q & ~clr_f;
				if (found_eff) begin
					victim_q <= scan_victim;
				end else begin
					pass_q <= pass_q + 2'd1;
				end
			end
			if (cmd.commit) begin
				ref_q[victim_q] <= 1'b1;
				if (hit_q) begin
					if (wr_q) begin
						mod_q[victim_q] <= 1'b1;
					end
				end else begin
					frame_page_q[victim_q] <= page_q;
					mod_q[victim_q]        <= wr_q;
					if (victim_q == ecpr_pkg::FRAME_W'(ecpr_pkg::FRAMES - 1)) begin
						hand_q <= '0;
					end else begin
						hand_q <= victim_q + 1'b1;
					end
				end
			end
		end
	end

	assign sts.hit   = hit_any;
	assign sts.found = found_eff;

	assign hit              = res_hit_q;
	assign frame_index      = res_idx_q;
	assign evicted_page     = res_page_q;
	assign evicted_modified = res_mod_q;

endmodule

// ----- rtl/enhanced_clock_page_replacement_top.sv -----
`timescale 1ns / 1ps
// Enhanced second-chance clock page replacement over a small set of frames.
// Input channel (in_valid/in_ready): one page access, page_number and is_write.
// Output channel (out_valid/out_ready): hit, frame_index, evicted_page and
// evicted_modified for that access, exactly one result item per input item.
// An accepted item goes through the LOOK state (tag lookup), then on a miss
// the SCAN state for one to four victim search passes, then the COMMIT state,
// which updates the frame table and loads the output register.
// The block takes no new item until the current one has committed; the
// search pass count sets how soon it is free again.
// in_ready is high while the block is idle, also while a result waits in the
// output register. If the receiver stalls, the next item is processed up to
// its commit and holds there until the pending result is taken.
// Reset (arst_n low) empties all frames (page 0, reference and modified bits
// clear), puts the clock hand at frame 0 and drops out_valid.
module enhanced_clock_page_replacement_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] page_number,
	input  logic        is_write,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        hit,
	output logic [1:0]  frame_index,
	output logic [15:0] evicted_page,
	output logic        evicted_modified
);

	ecpr_pkg::cmd_t cmd;
	ecpr_pkg::sts_t sts;

	ecpr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ecpr_datapath u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.page_number      (page_number),
		.is_write         (is_write),
		.hit              (hit),
		.frame_index      (frame_index),
		.evicted_page     (evicted_page),
		.evicted_modified (evicted_modified)
	);

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("accepted a second item while busy");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> (evicted_page == 16'd0) && !evicted_modified)
		else $error("hit reports an evicted page");

	a_result_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without an item in flight");

	a_one_command: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.look, cmd.scan, cmd.commit}))
		else $error("controller issued overlapping commands");
`endif

endmodule

// ----- dv/enhanced_clock_page_replacement_top_tb.sv -----
`timescale 1ns / 1ps
module enhanced_clock_page_replacement_top_tb;

	localparam int RANDOM_ITEMS = 550;
	localparam int IDLE_LIMIT   = 2000;
	localparam int LONG_HOLD    = 300;

	typedef struct packed {
		logic            hit;
		logic [1:0]      frame;
		ecpr_pkg::page_t evicted;
		logic            evicted_mod;
	} access_result_t;

	class replacement_scoreboard;
		ecpr_pkg::page_t frame_pg [ecpr_pkg::FRAMES];
		logic            ref_b [ecpr_pkg::FRAMES];
		logic            mod_b [ecpr_pkg::FRAMES];
		int unsigned     hand;
		access_result_t  pending [$];
		int              errors;

		function new();
			for (int i = 0; i < ecpr_pkg::FRAMES; i++) begin
				frame_pg[i] = '0;
				ref_b[i] = 1'b0;
				mod_b[i] = 1'b0;
			end
			hand = 0;
			errors = 0;
		endfunction

		// one sweep from the hand; optionally clears reference bits passed over
		function int sweep(logic want_mod, bit clear_passed);
			int f;
			for (int j = 0; j < ecpr_pkg::FRAMES; j++) begin
				f = (hand + j) % ecpr_pkg::FRAMES;
				if (!ref_b[f] && mod_b[f] == want_mod)
					return f;
				if (clear_passed)
					ref_b[f] = 1'b0;
			end
			return -1;
		endfunction

		function void note_access(ecpr_pkg::page_t pg, logic wr);
			access_result_t r;
			int v;
			r = '0;
			for (int i = 0; i < ecpr_pkg::FRAMES; i++) begin
				if (frame_pg[i] == pg) begin
					ref_b[i] = 1'b1;
					if (wr)
						mod_b[i] = 1'b1;
					r.hit = 1'b1;
					r.frame = i[1:0];
					pending.push_back(r);
					return;
				end
			end
			v = sweep(1'b0, 1'b0);
			if (v < 0)
				v = sweep(1'b1, 1'b1);
			if (v < 0)
				v = sweep(1'b0, 1'b0);
			if (v < 0)
				v = sweep(1'b1, 1'b1);
			if (v < 0)
				v = hand % ecpr_pkg::FRAMES;
			r.frame = v[1:0];
			r.evicted = frame_pg[v];
			r.evicted_mod = mod_b[v];
			frame_pg[v] = pg;
			ref_b[v] = 1'b1;
			mod_b[v] = wr;
			hand = (v + 1) % ecpr_pkg::FRAMES;
			pending.push_back(r);
		endfunction

		function void check_result(logic h, logic [1:0] fi, ecpr_pkg::page_t ep, logic em);
			access_result_t e;
			if (pending.size() == 0) begin
				$error("result item with no access outstanding");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (h !== e.hit) begin
				$error("hit: expected %0d, got %0d", e.hit, h);
				errors++;
			end
			if (fi !== e.frame) begin
				$error("frame_index: expected %0d, got %0d", e.frame, fi);
				errors++;
			end
			if (ep !== e.evicted) begin
				$error("evicted_page: expected %h, got %h", e.evicted, ep);
				errors++;
			end
			if (em !== e.evicted_mod) begin
				$error("evicted_modified: expected %0d, got %0d", e.evicted_mod, em);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [15:0] page_number = '0;
	logic        is_write = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        hit;
	logic [1:0]  frame_index;
	logic [15:0] evicted_page;
	logic        evicted_modified;

	replacement_scoreboard sb = new();
	int              in_count = 0;
	int              idle_cycles = 0;
	ecpr_pkg::page_t pool [8];
	int              pool_size = 4;

	enhanced_clock_page_replacement_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.page_number(page_number),
		.is_write(is_write),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.hit(hit),
		.frame_index(frame_index),
		.evicted_page(evicted_page),
		.evicted_modified(evicted_modified)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic send_access(input ecpr_pkg::page_t pg, input logic wr);
		in_valid <= 1'b1;
		page_number <= pg;
		is_write <= wr;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_access(pg, wr);
		in_count++;
	endtask

	function automatic void refresh_pool();
		pool_size = $urandom_range(3, 8);
		for (int i = 0; i < 8; i++) begin
			if ($urandom_range(0, 15) == 0)
				pool[i] = '0;
			else if ($urandom_range(0, 1) == 1)
				pool[i] = ecpr_pkg::page_t'($urandom_range(1, 12));
			else
				pool[i] = ecpr_pkg::page_t'($urandom_range(1, 65535));
		end
	endfunction

	function automatic ecpr_pkg::page_t next_page();
		if ($urandom_range(0, 9) == 0)
			return ecpr_pkg::page_t'($urandom_range(0, 65535));
		return pool[$urandom_range(0, pool_size - 1)];
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(hit, frame_index, evicted_page, evicted_modified);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[enhanced_clock_page_replacement_top] ERROR");
			$finish;
		end
	end

	// receiver: random stall modes plus one long hold-off
	initial begin
		int  mode;
		int  len;
		bit  held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && in_count >= 150) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			mode = $urandom_range(0, 2);
			len = $urandom_range(5, 60);
			repeat (len) begin
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	initial begin
		int burst;
		int gap;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// page zero hits an empty frame, then fill and force every search pass
		send_access(16'h0000, 1'b0);
		send_access(16'h0000, 1'b1);
		send_access(16'h0001, 1'b0);
		send_access(16'hFFFF, 1'b1);
		send_access(16'h8000, 1'b0);
		send_access(16'h5555, 1'b1);
		send_access(16'hAAAA, 1'b0);
		send_access(16'hFFFF, 1'b0);
		send_access(16'h0101, 1'b1);
		send_access(16'h0202, 1'b1);
		send_access(16'h0404, 1'b1);
		send_access(16'h0808, 1'b1);
		send_access(16'h0101, 1'b0);
		send_access(16'h0202, 1'b1);
		send_access(16'h0404, 1'b0);
		send_access(16'h0808, 1'b1);
		send_access(16'h1010, 1'b1);
		send_access(16'h0000, 1'b0);
		send_access(16'h0000, 1'b1);
		send_access(16'h7FFF, 1'b0);
		send_access(16'h1010, 1'b0);
		send_access(16'h0001, 1'b1);

		refresh_pool();
		while (in_count < RANDOM_ITEMS + 22) begin
			burst = $urandom_range(1, 30);
			repeat (burst) begin
				if ($urandom_range(0, 39) == 0)
					refresh_pool();
				send_access(next_page(), 1'($urandom_range(0, 1)));
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b0;

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("[enhanced_clock_page_replacement_top] OK");
		else
			$display("[enhanced_clock_page_replacement_top] ERROR");
		$finish;
	end
endmodule

// ----- enhanced_clock_page_replacement_top.f -----
rtl/ecpr_pkg.sv
rtl/ecpr_ctrl.sv
rtl/ecpr_datapath.sv
rtl/enhanced_clock_page_replacement_top.sv
dv/enhanced_clock_page_replacement_top_tb.sv
